// File: rtl/core/diatonic_note_transposer_defines.svh
// ---------------------------------------------------------------------------
// Diatonic note transposer assertion macros
// Shared property wrappers for the checker of the note transposer.
// ---------------------------------------------------------------------------
`ifndef DIATONIC_NOTE_TRANSPOSER_DEFINES_SVH
`define DIATONIC_NOTE_TRANSPOSER_DEFINES_SVH

// Same-cycle implication, disabled while rst is high.
`define DNT_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while rst is high.
`define DNT_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/core/dnt_pkg.sv
// ---------------------------------------------------------------------------
// Diatonic note transposer package
// Constants, scale tables, pipeline types and small helper functions.
// ---------------------------------------------------------------------------
package dnt_pkg;

   // Field widths.
   localparam int NOTE_W      = 7;
   localparam int OFFSET_W    = 8;
   localparam int KIND_W      = 4;
   localparam int ROOT_W      = 4;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 7;

   // Queue between the front and back parts, and the result queue.
   localparam int QUEUE_DEPTH = 8;
   localparam int QUEUE_PTR_W = 3;
   localparam int QUEUE_CNT_W = 4;
   localparam int OUT_DEPTH   = 4;
   localparam int OUT_PTR_W   = 2;
   localparam int OUT_CNT_W   = 3;

   // Most items the block can hold between input and result transfer.
   localparam int CAPACITY    = QUEUE_DEPTH + OUT_DEPTH;
   localparam int CAP_CNT_W   = 4;

   // Register indexes.
   localparam logic [CSR_INDEX_W-1:0] CSR_SCALE_KIND = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SCALE_ROOT = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_BASE_NOTE  = 2'd2;

   localparam logic [NOTE_W-1:0] BASE_NOTE_RESET = 7'd60;

   // Pitch classes and division by the octave: n / 12 = (n * 43) >> 9 for n < 128.
   localparam logic [3:0] PC_LAST     = 4'd11;
   localparam logic [5:0] DIV12_MUL   = 6'd43;
   localparam int         DIV12_SHIFT = 9;

   // Division by the scale size: j / s = (j * recip) >> 12 for j < 128.
   localparam int RECIP_SHIFT = 12;

   // Scale type codes.
   localparam logic [KIND_W-1:0] KIND_MAJOR        = 4'd0;
   localparam logic [KIND_W-1:0] KIND_NAT_MINOR    = 4'd1;
   localparam logic [KIND_W-1:0] KIND_DORIAN       = 4'd2;
   localparam logic [KIND_W-1:0] KIND_MIXOLYDIAN   = 4'd3;
   localparam logic [KIND_W-1:0] KIND_LYDIAN       = 4'd4;
   localparam logic [KIND_W-1:0] KIND_PHRYGIAN     = 4'd5;
   localparam logic [KIND_W-1:0] KIND_LOCRIAN      = 4'd6;
   localparam logic [KIND_W-1:0] KIND_HARM_MINOR   = 4'd7;
   localparam logic [KIND_W-1:0] KIND_MEL_MINOR    = 4'd8;
   localparam logic [KIND_W-1:0] KIND_MAJ_PENTA    = 4'd9;
   localparam logic [KIND_W-1:0] KIND_MIN_PENTA    = 4'd10;
   localparam logic [KIND_W-1:0] KIND_BLUES        = 4'd11;
   localparam logic [KIND_W-1:0] KIND_WHOLE_TONE   = 4'd12;
   localparam logic [KIND_W-1:0] KIND_DIM_HALF     = 4'd13;
   localparam logic [KIND_W-1:0] KIND_DIM_WHOLE    = 4'd14;
   localparam logic [KIND_W-1:0] KIND_CHROMATIC    = 4'd15;

   // Scale settings derived from the registers.
   typedef struct packed {
      logic [11:0] pc_mask;   // absolute pitch classes in the scale
      logic [3:0]  size;      // notes per octave
      logic [9:0]  recip;     // reciprocal of size for the division
      logic [7:0]  count;     // notes on the ladder from 0 to 127
   } scale_cfg_type;

   // Item passed from the front part to the back part.
   typedef struct packed {
      logic [NOTE_W-1:0]          idx;
      logic signed [OFFSET_W-1:0] shift;
      logic                       last;
   } step_type;

   // Result item.
   typedef struct packed {
      logic [NOTE_W-1:0] note;
      logic              last;
   } rsp_type;

   // Interval set of each scale type, bit i meaning i semitones above the root.
   function automatic logic [11:0] scale_mask(input logic [KIND_W-1:0] kind);
      logic [11:0] mask;
      case (kind)
         KIND_MAJOR:      mask = 12'hAB5;
         KIND_NAT_MINOR:  mask = 12'h5AD;
         KIND_DORIAN:     mask = 12'h6AD;
         KIND_MIXOLYDIAN: mask = 12'h6B5;
         KIND_LYDIAN:     mask = 12'hAD5;
         KIND_PHRYGIAN:   mask = 12'h5AB;
         KIND_LOCRIAN:    mask = 12'h56B;
         KIND_HARM_MINOR: mask = 12'h9AD;
         KIND_MEL_MINOR:  mask = 12'hAAD;
         KIND_MAJ_PENTA:  mask = 12'h295;
         KIND_MIN_PENTA:  mask = 12'h4A9;
         KIND_BLUES:      mask = 12'h4E9;
         KIND_WHOLE_TONE: mask = 12'h555;
         KIND_DIM_HALF:   mask = 12'h6DB;
         KIND_DIM_WHOLE:  mask = 12'hB6D;
         KIND_CHROMATIC:  mask = 12'hFFF;
         default:         mask = 12'hAB5;
      endcase
      return mask;
   endfunction

   function automatic logic [3:0] count_ones12(input logic [11:0] v);
      logic [3:0] total;
      total = 4'd0;
      for (int i = 0; i < 12; i++) begin
         total = total + {3'b000, v[i]};
      end
      return total;
   endfunction

   // Members of the mask below pitch class r.
   function automatic logic [3:0] prefix_ones(input logic [11:0] mask, input logic [3:0] r);
      logic [11:0] below;
      for (int i = 0; i < 12; i++) begin
         below[i] = (4'(i) < r);
      end
      return count_ones12(mask & below);
   endfunction

   // Pitch class of the m-th member of the mask, counted from zero.
   function automatic logic [3:0] nth_member(input logic [11:0] mask, input logic [3:0] m);
      logic [3:0] pc;
      pc = 4'd0;
      for (int i = 0; i < 12; i++) begin
         if (mask[i] && (prefix_ones(mask, 4'(i)) == m)) begin
            pc = 4'(i);
         end
      end
      return pc;
   endfunction

   // Moves an interval set onto absolute pitch classes for a root of 0 to 11.
   function automatic logic [11:0] rotate_pc(input logic [11:0] mask, input logic [3:0] root);
      logic [23:0] wide;
      wide = {mask, mask} << root;
      return wide[23:12];
   endfunction

   // Rounded-up 4096 / size for the sizes that the scales have.
   function automatic logic [9:0] scale_recip(input logic [3:0] size);
      logic [9:0] recip;
      case (size)
         4'd5:    recip = 10'd820;
         4'd6:    recip = 10'd683;
         4'd7:    recip = 10'd586;
         4'd8:    recip = 10'd512;
         default: recip = 10'd342;
      endcase
      return recip;
   endfunction

endpackage

// File: rtl/core/diatonic_note_transposer.sv
// ---------------------------------------------------------------------------
// Diatonic note transposer
// Places base note plus offset on the scale ladder of the configured root
// and scale type, then moves it by a number of scale degrees.
//
//   Channel   Ports                                  Transfer when
//   req       push full note_offset degree_shift     push and not full
//             last_in
//   rsp       empty pop out_note last_out            pop and not empty
//   csr       write index wdata                      write
//
// One item per cycle sustained unless the result side stalls. A result
// passes through four front stages, the step queue and two back stages
// ahead of the result queue.
// Reset is synchronous and empties both queues; the registers return to
// major, root 0 and base note 60.
// A stalled result side fills the result queue, then the step queue, and
// only then raises full.
// ---------------------------------------------------------------------------
module diatonic_note_transposer import dnt_pkg::*; (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_push,
   output logic                          req_full,
   input  logic signed [OFFSET_W-1:0]    req_note_offset,
   input  logic signed [OFFSET_W-1:0]    req_degree_shift,
   input  logic                          req_last_in,
   output logic                          rsp_empty,
   input  logic                          rsp_pop,
   output logic [NOTE_W-1:0]             rsp_out_note,
   output logic                          rsp_last_out,
   input  logic                          csr_write,
   input  logic [CSR_INDEX_W-1:0]        csr_index,
   input  logic [CSR_DATA_W-1:0]         csr_wdata
);

   logic [KIND_W-1:0]      scale_kind_ff, scale_kind_in;
   logic [ROOT_W-1:0]      scale_root_ff, scale_root_in;
   logic [NOTE_W-1:0]      base_note_ff, base_note_in;
   scale_cfg_type          cfg_ff, cfg_in;
   logic [ROOT_W-1:0]      root_pc;
   logic [11:0]            interval_mask;

   logic                   req_transfer;
   logic [2:0]             front_inflight;
   logic [QUEUE_CNT_W-1:0] queue_count;
   logic                   step_valid;
   step_type               front_step;
   step_type               queue_head;
   logic                   back_take;

   // Configuration register writes; unknown indexes are ignored.
   always_comb begin
      scale_kind_in = scale_kind_ff;
      scale_root_in = scale_root_ff;
      base_note_in  = base_note_ff;
      if (csr_write) begin
         case (csr_index)
            CSR_SCALE_KIND: scale_kind_in = csr_wdata[KIND_W-1:0];
            CSR_SCALE_ROOT: scale_root_in = csr_wdata[ROOT_W-1:0];
            CSR_BASE_NOTE:  base_note_in  = csr_wdata[NOTE_W-1:0];
            default:        ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scale_kind_ff <= KIND_MAJOR;
         scale_root_ff <= '0;
         base_note_ff  <= BASE_NOTE_RESET;
      end else begin
         scale_kind_ff <= scale_kind_in;
         scale_root_ff <= scale_root_in;
         base_note_ff  <= base_note_in;
      end
   end

   // Scale settings derived from the registers and held in a register of their own.
   always_comb begin
      root_pc        = (scale_root_ff > PC_LAST) ? scale_root_ff - 4'd12 : scale_root_ff;
      interval_mask  = scale_mask(scale_kind_ff);
      cfg_in.pc_mask = rotate_pc(interval_mask, root_pc);
      cfg_in.size    = count_ones12(interval_mask);
      cfg_in.recip   = scale_recip(cfg_in.size);
      // Ten whole octaves below 120, then the pitch classes of notes 120 to 127.
      cfg_in.count   = {1'b0, cfg_in.size, 3'b000} + {3'b000, cfg_in.size, 1'b0}
                     + {4'b0000, count_ones12(cfg_in.pc_mask & 12'h0FF)};
   end

   always_ff @(posedge clock) begin
      cfg_ff <= cfg_in;
   end

   // Input transfer: refused while the step queue could not hold every item in flight.
   assign req_full     = (queue_count + {1'b0, front_inflight}) >= QUEUE_CNT_W'(QUEUE_DEPTH);
   assign req_transfer = req_push && !req_full;

   dnt_front u_front (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg_ff),
      .base_note    (base_note_ff),
      .accept       (req_transfer),
      .note_offset  (req_note_offset),
      .degree_shift (req_degree_shift),
      .last_in      (req_last_in),
      .step_valid   (step_valid),
      .step         (front_step),
      .inflight     (front_inflight)
   );

   dnt_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (step_valid),
      .push_data (front_step),
      .pop       (back_take),
      .head      (queue_head),
      .count     (queue_count)
   );

   dnt_back u_back (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg_ff),
      .has_step     (queue_count != '0),
      .step         (queue_head),
      .take         (back_take),
      .rsp_empty    (rsp_empty),
      .rsp_pop      (rsp_pop),
      .rsp_out_note (rsp_out_note),
      .rsp_last_out (rsp_last_out)
   );

endmodule

// File: rtl/core/dnt_front.sv
// ---------------------------------------------------------------------------
// Note transposer front part
// Accepts items and locates the target note on the scale ladder, snapping
// it to the nearest ladder note. Four register stages, one item per cycle.
// ---------------------------------------------------------------------------
module dnt_front import dnt_pkg::*; (
   input  logic                       clock,
   input  logic                       reset,
   input  scale_cfg_type              cfg,
   input  logic [NOTE_W-1:0]          base_note,
   input  logic                       accept,
   input  logic signed [OFFSET_W-1:0] note_offset,
   input  logic signed [OFFSET_W-1:0] degree_shift,
   input  logic                       last_in,
   output logic                       step_valid,
   output step_type                   step,
   output logic [2:0]                 inflight
);

   // Stage 1: target note.
   logic                       v1_ff, v1_in;
   logic signed [9:0]          t1_ff, t1_in;
   logic signed [OFFSET_W-1:0] shift1_ff;
   logic                       last1_ff;

   // Stage 2: range flags and octave.
   logic                       v2_ff;
   logic                       lo2_ff, lo2_in;
   logic                       hi2_ff, hi2_in;
   logic [NOTE_W-1:0]          n2_ff;
   logic [3:0]                 q2_ff, q2_in;
   logic signed [OFFSET_W-1:0] shift2_ff;
   logic                       last2_ff;
   logic [12:0]                div_prod;

   // Stage 3: ladder position.
   logic                       v3_ff;
   logic [NOTE_W-1:0]          pos3_ff, pos3_in;
   logic                       on3_ff, on3_in;
   logic                       lower3_ff, lower3_in;
   logic                       lo3_ff, hi3_ff;
   logic signed [OFFSET_W-1:0] shift3_ff;
   logic                       last3_ff;
   logic [6:0]                 twelve_q;
   logic [6:0]                 pc_diff;
   logic [3:0]                 pc;
   logic [3:0]                 pc_below;
   logic [3:0]                 pc_above;
   logic [7:0]                 octave_base;
   logic [7:0]                 pos_sum;

   // Stage 4: ladder index.
   logic                       v4_ff;
   logic [NOTE_W-1:0]          idx4_ff, idx4_in;
   logic signed [OFFSET_W-1:0] shift4_ff;
   logic                       last4_ff;
   logic [7:0]                 count_m1;

   // Target note, wide enough for both ends of the offset range.
   always_comb begin
      v1_in = accept;
      t1_in = $signed({3'b000, base_note}) + $signed({{2{note_offset[7]}}, note_offset});
   end

   // Off the bottom, off the top, and the octave by reciprocal multiplication.
   always_comb begin
      lo2_in   = t1_ff[9];
      hi2_in   = !t1_ff[9] && (t1_ff[8:7] != 2'b00);
      div_prod = t1_ff[6:0] * DIV12_MUL;
      q2_in    = div_prod[12:DIV12_SHIFT];
   end

   // Count of ladder notes below the target and its neighbours in the scale.
   always_comb begin
      twelve_q    = {q2_ff, 3'b000} + {1'b0, q2_ff, 2'b00};
      pc_diff     = n2_ff - twelve_q;
      pc          = pc_diff[3:0];
      pc_below    = (pc == 4'd0) ? PC_LAST : pc - 4'd1;
      pc_above    = (pc == PC_LAST) ? 4'd0 : pc + 4'd1;
      octave_base = q2_ff * cfg.size;
      pos_sum     = octave_base + {4'b0000, prefix_ones(cfg.pc_mask, pc)};
      pos3_in     = pos_sum[NOTE_W-1:0];
      on3_in      = cfg.pc_mask[pc];
      // The gap is at most three semitones, so each neighbour is one or two away;
      // the lower one wins unless it is two away and the upper one is one away.
      lower3_in   = cfg.pc_mask[pc_below] || !cfg.pc_mask[pc_above];
   end

   // Ladder index, with snapping and clamping at the ladder ends.
   always_comb begin
      count_m1 = cfg.count - 8'd1;
      if (lo3_ff) begin
         idx4_in = '0;
      end else if (hi3_ff) begin
         idx4_in = count_m1[NOTE_W-1:0];
      end else if (on3_ff) begin
         idx4_in = pos3_ff;
      end else if (pos3_ff == '0) begin
         idx4_in = '0;
      end else if ({1'b0, pos3_ff} == cfg.count) begin
         idx4_in = count_m1[NOTE_W-1:0];
      end else if (lower3_ff) begin
         idx4_in = pos3_ff - 7'd1;
      end else begin
         idx4_in = pos3_ff;
      end
   end

   // Valid bits.
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
   end

   // Payload stages.
   always_ff @(posedge clock) begin
      t1_ff     <= t1_in;
      shift1_ff <= degree_shift;
      last1_ff  <= last_in;

      lo2_ff    <= lo2_in;
      hi2_ff    <= hi2_in;
      n2_ff     <= t1_ff[6:0];
      q2_ff     <= q2_in;
      shift2_ff <= shift1_ff;
      last2_ff  <= last1_ff;

      pos3_ff   <= pos3_in;
      on3_ff    <= on3_in;
      lower3_ff <= lower3_in;
      lo3_ff    <= lo2_ff;
      hi3_ff    <= hi2_ff;
      shift3_ff <= shift2_ff;
      last3_ff  <= last2_ff;

      idx4_ff   <= idx4_in;
      shift4_ff <= shift3_ff;
      last4_ff  <= last3_ff;
   end

   assign step_valid = v4_ff;
   assign step.idx   = idx4_ff;
   assign step.shift = shift4_ff;
   assign step.last  = last4_ff;
   assign inflight   = {2'b00, v1_ff} + {2'b00, v2_ff} + {2'b00, v3_ff} + {2'b00, v4_ff};

endmodule

// File: rtl/core/dnt_queue.sv
// ---------------------------------------------------------------------------
// Note transposer step queue
// Small first-in first-out queue that decouples the front and back parts.
// ---------------------------------------------------------------------------
module dnt_queue import dnt_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  step_type               push_data,
   input  logic                   pop,
   output step_type               head,
   output logic [QUEUE_CNT_W-1:0] count
);

   step_type                entries_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0]  count_ff, count_in;

   // Pointer and fill count update.
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + {{(QUEUE_CNT_W-1){1'b0}}, push}
                           - {{(QUEUE_CNT_W-1){1'b0}}, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage.
   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign head  = entries_ff[rd_ptr_ff];
   assign count = count_ff;

endmodule

// File: rtl/core/dnt_back.sv
// ---------------------------------------------------------------------------
// Note transposer back part
// Moves the ladder index by the degree shift, turns the index back into a
// note number and holds finished results in a short result queue.
// ---------------------------------------------------------------------------
module dnt_back import dnt_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  scale_cfg_type     cfg,
   input  logic              has_step,
   input  step_type          step,
   output logic              take,
   output logic              rsp_empty,
   input  logic              rsp_pop,
   output logic [NOTE_W-1:0] rsp_out_note,
   output logic              rsp_last_out
);

   // Stage 1: shifted and clamped index.
   logic              v1_ff;
   logic [NOTE_W-1:0] j1_ff, j1_in;
   logic              last1_ff;
   logic [9:0]        shifted;
   logic              below_zero;
   logic              past_top;
   logic [7:0]        count_m1;

   // Stage 2: octave of the index.
   logic              v2_ff;
   logic [NOTE_W-1:0] j2_ff;
   logic [4:0]        qs2_ff, qs2_in;
   logic              last2_ff;
   logic [16:0]       recip_prod;

   // Note number.
   logic [8:0]        qs_scaled;
   logic [8:0]        member_diff;
   logic [3:0]        member;
   logic [8:0]        twelve_qs;
   logic [8:0]        note_sum;
   rsp_type           result;

   // Result queue.
   rsp_type              rsp_q_ff [OUT_DEPTH];
   logic [OUT_PTR_W-1:0] rsp_wr_ff, rsp_wr_in;
   logic [OUT_PTR_W-1:0] rsp_rd_ff, rsp_rd_in;
   logic [OUT_CNT_W-1:0] rsp_cnt_ff, rsp_cnt_in;
   logic [OUT_CNT_W-1:0] reserved;
   logic                 rsp_transfer;

   // Take a step only when the result queue has a free place for it.
   always_comb begin
      reserved = rsp_cnt_ff + {{(OUT_CNT_W-1){1'b0}}, v1_ff}
                            + {{(OUT_CNT_W-1){1'b0}}, v2_ff};
      take     = has_step && (reserved < OUT_CNT_W'(OUT_DEPTH));
   end

   // Shift along the ladder and clamp to its ends.
   always_comb begin
      shifted    = {3'b000, step.idx} + {{2{step.shift[7]}}, step.shift};
      below_zero = shifted[9];
      past_top   = !shifted[9] && (shifted[8:0] >= {1'b0, cfg.count});
      count_m1   = cfg.count - 8'd1;
      if (below_zero) begin
         j1_in = '0;
      end else if (past_top) begin
         j1_in = count_m1[NOTE_W-1:0];
      end else begin
         j1_in = shifted[NOTE_W-1:0];
      end
   end

   // Octave of the index by reciprocal multiplication.
   always_comb begin
      recip_prod = j1_ff * cfg.recip;
      qs2_in     = recip_prod[16:RECIP_SHIFT];
   end

   // Scale member within the octave and the note number.
   always_comb begin
      qs_scaled   = qs2_ff * cfg.size;
      member_diff = {2'b00, j2_ff} - qs_scaled;
      member      = member_diff[3:0];
      twelve_qs   = {1'b0, qs2_ff, 3'b000} + {2'b00, qs2_ff, 2'b00};
      note_sum    = twelve_qs + {5'b00000, nth_member(cfg.pc_mask, member)};
      result.note = note_sum[NOTE_W-1:0];
      result.last = last2_ff;
   end

   // Result queue control.
   always_comb begin
      rsp_transfer = rsp_pop && (rsp_cnt_ff != '0);
      rsp_wr_in    = v2_ff ? rsp_wr_ff + 1'b1 : rsp_wr_ff;
      rsp_rd_in    = rsp_transfer ? rsp_rd_ff + 1'b1 : rsp_rd_ff;
      rsp_cnt_in   = rsp_cnt_ff + {{(OUT_CNT_W-1){1'b0}}, v2_ff}
                                - {{(OUT_CNT_W-1){1'b0}}, rsp_transfer};
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff      <= 1'b0;
         v2_ff      <= 1'b0;
         rsp_wr_ff  <= '0;
         rsp_rd_ff  <= '0;
         rsp_cnt_ff <= '0;
      end else begin
         v1_ff      <= take;
         v2_ff      <= v1_ff;
         rsp_wr_ff  <= rsp_wr_in;
         rsp_rd_ff  <= rsp_rd_in;
         rsp_cnt_ff <= rsp_cnt_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      j1_ff    <= j1_in;
      last1_ff <= step.last;
      j2_ff    <= j1_ff;
      qs2_ff   <= qs2_in;
      last2_ff <= last1_ff;
      if (v2_ff) begin
         rsp_q_ff[rsp_wr_ff] <= result;
      end
   end

   assign rsp_empty    = (rsp_cnt_ff == '0);
   assign rsp_out_note = rsp_q_ff[rsp_rd_ff].note;
   assign rsp_last_out = rsp_q_ff[rsp_rd_ff].last;

endmodule

// File: rtl/core/dnt_checker.sv
// ---------------------------------------------------------------------------
// Note transposer port checker
// Watches the queue-style ports and counts items held inside the block.
// ---------------------------------------------------------------------------
`include "diatonic_note_transposer_defines.svh"

module dnt_checker import dnt_pkg::*; (
   input logic              clock,
   input logic              reset,
   input logic              req_push,
   input logic              req_full,
   input logic              rsp_empty,
   input logic              rsp_pop,
   input logic [NOTE_W-1:0] rsp_out_note,
   input logic              rsp_last_out
);

   logic [CAP_CNT_W-1:0] held_ff, held_in;
   logic                 in_transfer;
   logic                 out_transfer;

   // Items transferred in and not yet transferred out.
   always_comb begin
      in_transfer  = req_push && !req_full;
      out_transfer = rsp_pop && !rsp_empty;
      held_in      = held_ff + {{(CAP_CNT_W-1){1'b0}}, in_transfer}
                             - {{(CAP_CNT_W-1){1'b0}}, out_transfer};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff <= '0;
      end else begin
         held_ff <= held_in;
      end
   end

   // Reset leaves both queues empty.
   `DNT_ASSERT_NXT(a_reset_clears, clock, 1'b0, reset, rsp_empty && !req_full, "not empty after reset")

   // A waiting result stays put until it is taken.
   `DNT_ASSERT_NXT(a_rsp_hold, clock, reset, !rsp_empty && !rsp_pop, !rsp_empty && $stable(rsp_out_note) && $stable(rsp_last_out), "waiting result changed")

   // No result without an item that caused it.
   `DNT_ASSERT_IMP(a_no_phantom, clock, reset, !rsp_empty, held_ff != '0, "result with no item held")

   // Input is refused once every place inside the block is taken.
   `DNT_ASSERT_IMP(a_full_at_capacity, clock, reset, held_ff >= CAP_CNT_W'(CAPACITY), req_full, "not full at capacity")

endmodule

bind diatonic_note_transposer dnt_checker u_dnt_checker (.*);
